### rtl/sctb_pkg.sv
// Package with request and result types, address map, timer constants and boot ROM image.
package sctb_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_READ    = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_HOST_WR = 3'd3,
    CMD_HOST_RD = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [1:0]  host_port;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ram_access;
    logic       dsp_read;
    logic       dsp_write;
    logic [6:0] dsp_reg;
    logic       dsp_step;
  } out_t;

  typedef struct packed {
    logic       tick;
    logic       ctl_wr;
    logic       tgt_wr;
    logic       cnt_rd;
    logic [1:0] sel;
    logic [7:0] data;
  } timer_ctrl_t;

  localparam int NUM_TIMERS = 3;
  localparam int NUM_PORTS  = 4;

  localparam logic [7:0] ADR_TEST     = 8'hf0;
  localparam logic [7:0] ADR_CONTROL  = 8'hf1;
  localparam logic [7:0] ADR_DSP_ADDR = 8'hf2;
  localparam logic [7:0] ADR_DSP_DATA = 8'hf3;
  localparam logic [7:0] ADR_PORT0    = 8'hf4;
  localparam logic [7:0] ADR_PORT3    = 8'hf7;
  localparam logic [7:0] ADR_TARGET0  = 8'hfa;
  localparam logic [7:0] ADR_TARGET2  = 8'hfc;
  localparam logic [7:0] ADR_COUNTER0 = 8'hfd;
  localparam logic [7:0] ADR_COUNTER2 = 8'hff;
  localparam logic [15:0] ADR_ROM_BASE = 16'hffc0;

  localparam logic [1:0] TARGET_BIAS  = 2'd2;
  localparam logic [1:0] COUNTER_BIAS = 2'd1;

  localparam logic [7:0] PRESCALE_SLOW = 8'd128;
  localparam logic [7:0] PRESCALE_FAST = 8'd16;

  localparam int CTL_CLEAR_LO = 4;
  localparam int CTL_CLEAR_HI = 5;
  localparam int CTL_ROM_HIDE = 7;

  localparam logic [7:0] BOOT_ROM [0:63] = '{
    8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0, 8'hfc, 8'h8f, 8'haa,
    8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78, 8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19,
    8'heb, 8'hf4, 8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5, 8'hcb,
    8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab, 8'h01, 8'h10, 8'hef, 8'h7e,
    8'hf4, 8'h10, 8'heb, 8'hba, 8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4,
    8'hdd, 8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
  };

endpackage

### rtl/sctb_timers.sv
// Three interval timers with prescalers, dividers, targets and 4-bit counters.
module sctb_timers (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sctb_pkg::timer_ctrl_t   ctrl,
  output logic [2:0][3:0]         cnt_ticked
);

  logic [2:0][7:0] pre_r, pre_nxt;
  logic [2:0][7:0] div_r, div_nxt;
  logic [2:0][7:0] tgt_r, tgt_nxt;
  logic [2:0][3:0] cnt_r, cnt_nxt;
  logic [2:0]      on_r, on_nxt;

  always_comb begin
    for (int t = 0; t < sctb_pkg::NUM_TIMERS; t++) begin
      pre_nxt[t] = pre_r[t];
      div_nxt[t] = div_r[t];
      tgt_nxt[t] = tgt_r[t];
      cnt_nxt[t] = cnt_r[t];
      on_nxt[t]  = on_r[t];
      if (ctrl.tick) begin
        if (pre_r[t] == 8'd0) begin
          pre_nxt[t] = ((t == 2) ? sctb_pkg::PRESCALE_FAST : sctb_pkg::PRESCALE_SLOW) - 8'd1;
          if (on_r[t]) begin
            div_nxt[t] = div_r[t] + 8'd1;
            if (div_nxt[t] == tgt_r[t]) begin
              div_nxt[t] = 8'd0;
              cnt_nxt[t] = cnt_r[t] + 4'd1;
            end
          end
        end else begin
          pre_nxt[t] = pre_r[t] - 8'd1;
        end
      end
      cnt_ticked[t] = cnt_nxt[t];
      if (ctrl.ctl_wr) begin
        if (!on_r[t] && ctrl.data[t]) begin
          div_nxt[t] = 8'd0;
          cnt_nxt[t] = 4'd0;
        end
        on_nxt[t] = ctrl.data[t];
      end
      if (ctrl.tgt_wr && ctrl.sel == 2'(t)) begin
        tgt_nxt[t] = ctrl.data;
      end
      if (ctrl.cnt_rd && ctrl.sel == 2'(t)) begin
        cnt_nxt[t] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= '0;
      div_r <= '0;
      tgt_r <= '0;
      cnt_r <= '0;
      on_r  <= '0;
    end else begin
      pre_r <= pre_nxt;
      div_r <= div_nxt;
      tgt_r <= tgt_nxt;
      cnt_r <= cnt_nxt;
      on_r  <= on_nxt;
    end
  end

endmodule

### rtl/sound_cpu_io_timer_block.sv
// Top level of the sound processor I/O page, timers, mailbox ports and boot ROM.
// All decode and state updates sit in one stage between the input and result registers.
// Throughput: one request per cycle while out_stall is low.
// The input register and the result register let a new request enter while a result waits.
// Reset is synchronous and active low: timers stop and clear, ports clear, boot ROM is shown.
module sound_cpu_io_timer_block (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sctb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sctb_pkg::out_t out_data
);

  logic           s1_valid_r, s1_valid_nxt;
  sctb_pkg::in_t  s1_r;
  logic           out_valid_r, out_valid_nxt;
  sctb_pkg::out_t out_r, out_nxt;

  logic                  boot_vis_r, boot_vis_nxt;
  logic [7:0]            dsp_sel_r, dsp_sel_nxt;
  logic [4:0]            phase_r, phase_nxt;
  logic [3:0][7:0]       h2c_r, h2c_nxt;
  logic [3:0][7:0]       c2h_r, c2h_nxt;

  sctb_pkg::timer_ctrl_t tctrl;
  logic [2:0][3:0]       cnt_ticked;

  logic adv;
  logic is_rd, is_wr, is_tick;
  logic io_page;
  logic [7:0] lo;
  logic in_ports, in_targets, in_counters;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_rd   = (s1_r.command == sctb_pkg::CMD_READ);
  assign is_wr   = (s1_r.command == sctb_pkg::CMD_WRITE);
  assign is_tick = is_rd || is_wr || (s1_r.command == sctb_pkg::CMD_IDLE);

  assign io_page     = (s1_r.address[15:8] == 8'd0);
  assign lo          = s1_r.address[7:0];
  assign in_ports    = io_page && lo >= sctb_pkg::ADR_PORT0 && lo <= sctb_pkg::ADR_PORT3;
  assign in_targets  = io_page && lo >= sctb_pkg::ADR_TARGET0 && lo <= sctb_pkg::ADR_TARGET2;
  assign in_counters = io_page && lo >= sctb_pkg::ADR_COUNTER0 && lo <= sctb_pkg::ADR_COUNTER2;

  always_comb begin
    tctrl.tick   = adv && is_tick;
    tctrl.ctl_wr = adv && is_wr && io_page && lo == sctb_pkg::ADR_CONTROL;
    tctrl.tgt_wr = adv && is_wr && in_targets;
    tctrl.cnt_rd = adv && is_rd && in_counters;
    tctrl.sel    = in_targets ? lo[1:0] - sctb_pkg::TARGET_BIAS
                              : lo[1:0] - sctb_pkg::COUNTER_BIAS;
    tctrl.data   = s1_r.write_data;
  end

  sctb_timers u_timers (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (tctrl),
    .cnt_ticked (cnt_ticked)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt      = '0;
    boot_vis_nxt = boot_vis_r;
    dsp_sel_nxt  = dsp_sel_r;
    phase_nxt    = phase_r;
    h2c_nxt      = h2c_r;
    c2h_nxt      = c2h_r;
    if (adv) begin
      if (is_tick) begin
        out_nxt.dsp_step = (phase_r == 5'd0);
        phase_nxt        = phase_r + 5'd1;
      end
      case (s1_r.command)
        sctb_pkg::CMD_READ: begin
          if (io_page && lo == sctb_pkg::ADR_DSP_ADDR) begin
            out_nxt.read_data = dsp_sel_r;
          end else if (io_page && lo == sctb_pkg::ADR_DSP_DATA) begin
            out_nxt.dsp_read = 1'b1;
            out_nxt.dsp_reg  = dsp_sel_r[6:0];
          end else if (in_ports) begin
            out_nxt.read_data = h2c_r[lo[1:0]];
          end else if (in_counters) begin
            out_nxt.read_data = {4'd0, cnt_ticked[tctrl.sel]};
          end else if (io_page && (lo == sctb_pkg::ADR_TEST || lo == sctb_pkg::ADR_CONTROL
                                   || in_targets)) begin
            out_nxt.read_data = 8'd0;
          end else if (boot_vis_r && s1_r.address >= sctb_pkg::ADR_ROM_BASE) begin
            out_nxt.read_data = sctb_pkg::BOOT_ROM[s1_r.address[5:0]];
          end else begin
            out_nxt.ram_access = 1'b1;
          end
        end
        sctb_pkg::CMD_WRITE: begin
          out_nxt.ram_access = 1'b1;
          if (io_page && lo == sctb_pkg::ADR_CONTROL) begin
            if (s1_r.write_data[sctb_pkg::CTL_CLEAR_LO]) begin
              h2c_nxt[0] = 8'd0;
              h2c_nxt[1] = 8'd0;
            end
            if (s1_r.write_data[sctb_pkg::CTL_CLEAR_HI]) begin
              h2c_nxt[2] = 8'd0;
              h2c_nxt[3] = 8'd0;
            end
            boot_vis_nxt = !s1_r.write_data[sctb_pkg::CTL_ROM_HIDE];
          end else if (io_page && lo == sctb_pkg::ADR_DSP_ADDR) begin
            dsp_sel_nxt = s1_r.write_data;
          end else if (io_page && lo == sctb_pkg::ADR_DSP_DATA) begin
            if (!dsp_sel_r[7]) begin
              out_nxt.dsp_write = 1'b1;
              out_nxt.dsp_reg   = dsp_sel_r[6:0];
            end
          end else if (in_ports) begin
            c2h_nxt[lo[1:0]] = s1_r.write_data;
          end
        end
        sctb_pkg::CMD_HOST_WR: begin
          h2c_nxt[s1_r.host_port] = s1_r.write_data;
        end
        sctb_pkg::CMD_HOST_RD: begin
          out_nxt.read_data = c2h_r[s1_r.host_port];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      boot_vis_r  <= 1'b1;
      dsp_sel_r   <= '0;
      phase_r     <= '0;
      h2c_r       <= '0;
      c2h_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      boot_vis_r  <= boot_vis_nxt;
      dsp_sel_r   <= dsp_sel_nxt;
      phase_r     <= phase_nxt;
      h2c_r       <= h2c_nxt;
      c2h_r       <= c2h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r))
    else $error("Tick phase moved without a request.");

  a_host_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_r.command == sctb_pkg::CMD_HOST_WR || s1_r.command == sctb_pkg::CMD_HOST_RD)
    |=> !out_r.dsp_step)
    else $error("Host access raised a DSP step.");

  a_dsp_high_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_wr && dsp_sel_r[7] |=> !out_r.dsp_write)
    else $error("DSP write passed with the select high bit set.");

  a_dsp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.dsp_read && out_r.dsp_write))
    else $error("DSP read and write flagged together.");

endmodule
